// ----- rtl/core/calendar_to_epoch_seconds_core_assert.svh -----
// Assertion macros shared by the calendar conversion core.
// Needs the clock and reset signals of the module that includes it.
`ifndef CALENDAR_TO_EPOCH_SECONDS_CORE_ASSERT_SVH
`define CALENDAR_TO_EPOCH_SECONDS_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define C2ES_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("c2es: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define C2ES_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c2es: next-cycle check failed");

`endif

// ----- rtl/core/c2es_pkg.sv -----
// Package for the calendar to epoch seconds core: widths, the decoded date structure
// and the days-before-month table. No dependencies.
package c2es_pkg;

   localparam int unsigned REQ_W  = 40;
   localparam int unsigned RSP_W  = 40;
   localparam int unsigned YEAR_W = 8;
   localparam int unsigned DAY_W  = 17;
   localparam int unsigned HOUR_W = 22;
   localparam int unsigned MIN_W  = 28;
   localparam int unsigned SEC_W  = 33;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR = 8'd70;

   typedef struct packed {
      logic              ok;
      logic [YEAR_W-1:0] year;
      logic              leap_add;
      logic [8:0]        month_days;
      logic [4:0]        day_ofs;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
   } c2es_date_type;

   function automatic logic [8:0] month_days_before(input logic [3:0] month);
      logic [8:0] d;
      case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ----- rtl/core/c2es_decode.sv -----
// Field checks, hour-24 rollover, year selection and month lookup for one word.
// Depends on c2es_pkg.
module c2es_decode
   import c2es_pkg::*;
(
   input  logic [8:0]        year_raw,
   input  logic [3:0]        month,
   input  logic [5:0]        day,
   input  logic [4:0]        hour,
   input  logic [5:0]        minute,
   input  logic [5:0]        second,
   input  logic [YEAR_W-1:0] current_year,
   output c2es_date_type     date
);

   logic       month_ok;
   logic       day_ok;
   logic       roll;
   logic [4:0] hour_n;

   always_comb begin
      month_ok = month inside {[4'd1:4'd12]};
      day_ok   = day inside {[6'd1:6'd31]};
      roll     = (hour == 5'd24);
      hour_n   = roll ? 5'd0 : hour;

      date.ok         = month_ok && day_ok && (minute <= 6'd59) && (hour_n <= 5'd23);
      date.year       = year_raw[8] ? current_year : year_raw[YEAR_W-1:0];
      date.leap_add   = (date.year[1:0] == 2'd0) && (month >= 4'd3);
      date.month_days = month_days_before(month);
      // After a rollover the day goes up by one, so its offset is the day itself.
      date.day_ofs    = roll ? day[4:0] : day[4:0] - 5'd1;
      date.hour       = hour_n;
      date.minute     = minute;
      date.second     = second;
   end

endmodule

// ----- rtl/core/calendar_to_epoch_seconds_core.sv -----
// An accepted req word passes the six stages s1 to s5 and the rsp register to rsp_tvalid;
// one word per cycle while the rsp side does not stall, each stage holding one word.
// Every stage moves on when the stage after it is empty or moving, so a stalled
// rsp side still lets words fill the empty stages behind it.
// Reset empties the pipeline and sets current_year to 70; no clearing pass.
`include "calendar_to_epoch_seconds_core_assert.svh"

module calendar_to_epoch_seconds_core
   import c2es_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // year_since_1900[8:0], month[12:9], day[18:13], hour[23:19],
   // minute[29:24], second[35:30], zero fill up to bit 39
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // epoch_seconds[32:0], zero fill up to bit 39
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   logic [YEAR_W-1:0] cur_year_ff;
   c2es_date_type     date;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   c2es_date_type     s1_ff;

   logic              s2_ok_ff;
   logic [DAY_W-1:0]  s2_year_days_ff;
   logic [8:0]        s2_month_days_ff;
   logic              s2_leap_ff;
   logic [4:0]        s2_day_ofs_ff;
   logic [4:0]        s2_hour_ff;
   logic [5:0]        s2_minute_ff;
   logic [5:0]        s2_second_ff;

   logic              s3_ok_ff;
   logic [DAY_W-1:0]  s3_days_ff;
   logic [4:0]        s3_hour_ff;
   logic [5:0]        s3_minute_ff;
   logic [5:0]        s3_second_ff;

   logic              s4_ok_ff;
   logic [HOUR_W-1:0] s4_hours_ff;
   logic [5:0]        s4_minute_ff;
   logic [5:0]        s4_second_ff;

   logic              s5_ok_ff;
   logic [MIN_W-1:0]  s5_mins_ff;
   logic [5:0]        s5_second_ff;

   logic [SEC_W-1:0]  rsp_data_ff;

   logic [DAY_W-1:0]  year_days_in;
   logic [6:0]        leap_count;
   logic [DAY_W-1:0]  days_in;
   logic [HOUR_W-1:0] hours_in;
   logic [MIN_W-1:0]  mins_in;
   logic [SEC_W-1:0]  secs_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_year_ff <= EPOCH_YEAR;
      end else if (csr_valid && csr_ready) begin
         cur_year_ff <= csr_data;
      end
   end

   c2es_decode u_decode (
      .year_raw     (req_tdata[8:0]),
      .month        (req_tdata[12:9]),
      .day          (req_tdata[18:13]),
      .hour         (req_tdata[23:19]),
      .minute       (req_tdata[29:24]),
      .second       (req_tdata[35:30]),
      .current_year (cur_year_ff),
      .date         (date)
   );

   assign rdy6       = !v6_ff || rsp_tready;
   assign rdy5       = !v5_ff || rdy6;
   assign rdy4       = !v4_ff || rdy5;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_comb begin
      // Years divisible by four from 1972 up to the year before: (year + 3) / 4 - 18.
      leap_count = 7'(({1'b0, s1_ff.year} + 9'd3) >> 2) - 7'd18;
      if (s1_ff.year > EPOCH_YEAR) begin
         year_days_in = DAY_W'(s1_ff.year - EPOCH_YEAR) * DAY_W'(365)
                        + DAY_W'(leap_count);
      end else begin
         year_days_in = '0;
      end
      days_in  = s2_year_days_ff + DAY_W'(s2_month_days_ff) + DAY_W'(s2_leap_ff)
                 + DAY_W'(s2_day_ofs_ff);
      hours_in = HOUR_W'(s3_days_ff) * HOUR_W'(24) + HOUR_W'(s3_hour_ff);
      mins_in  = MIN_W'(s4_hours_ff) * MIN_W'(60) + MIN_W'(s4_minute_ff);
      secs_in  = SEC_W'(s5_mins_ff) * SEC_W'(60) + SEC_W'(s5_second_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= date;
      end
      if (rdy2) begin
         s2_ok_ff         <= s1_ff.ok;
         s2_year_days_ff  <= year_days_in;
         s2_month_days_ff <= s1_ff.month_days;
         s2_leap_ff       <= s1_ff.leap_add;
         s2_day_ofs_ff    <= s1_ff.day_ofs;
         s2_hour_ff       <= s1_ff.hour;
         s2_minute_ff     <= s1_ff.minute;
         s2_second_ff     <= s1_ff.second;
      end
      if (rdy3) begin
         s3_ok_ff     <= s2_ok_ff;
         s3_days_ff   <= days_in;
         s3_hour_ff   <= s2_hour_ff;
         s3_minute_ff <= s2_minute_ff;
         s3_second_ff <= s2_second_ff;
      end
      if (rdy4) begin
         s4_ok_ff     <= s3_ok_ff;
         s4_hours_ff  <= hours_in;
         s4_minute_ff <= s3_minute_ff;
         s4_second_ff <= s3_second_ff;
      end
      if (rdy5) begin
         s5_ok_ff     <= s4_ok_ff;
         s5_mins_ff   <= mins_in;
         s5_second_ff <= s4_second_ff;
      end
      if (rdy6) begin
         rsp_data_ff <= s5_ok_ff ? secs_in : '0;
      end
   end

   assign rsp_tvalid = v6_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   `C2ES_ASSERT_SAME(a_ready_chain, rsp_tready, req_tready)
   `C2ES_ASSERT_NEXT(a_accept_fills, req_tvalid && req_tready, v1_ff)
   `C2ES_ASSERT_NEXT(a_mid_stall_holds, v3_ff && !rdy4, v3_ff && $stable(s3_days_ff))
   `C2ES_ASSERT_NEXT(a_drain_empties, rsp_tvalid && rsp_tready && !v5_ff, !rsp_tvalid)

endmodule

// ----- tb/calendar_to_epoch_seconds_core_test.sv -----
// Self-checking testbench for calendar_to_epoch_seconds_core: directed and random calendar words
// are checked against an in-bench prediction of the epoch seconds, under several current years.
// Depends on c2es_pkg and the core RTL only.
`timescale 1ns / 100ps

module calendar_to_epoch_seconds_core_test;
   import c2es_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned ITEMS_PER_PHASE = 285;
   localparam int unsigned LONG_HOLD = 150;
   localparam logic [8:0] YEAR_NEG_ONE = 9'h1FF;
   localparam logic [8:0] YEAR_NEG_MIN = 9'h100;
   localparam int unsigned DAYS_TO_MONTH [12] =
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   typedef struct packed {
      logic [3:0] fill;
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [5:0] day;
      logic [3:0] month;
      logic [8:0] year;
   } calendar_word_type;

   typedef enum logic [1:0] {
      READY_ALWAYS, READY_HALF, READY_QUARTER, READY_MOSTLY
   } stall_mode_type;

   class epoch_scoreboard;
      bit [7:0] current_year;
      bit [32:0] pending_epochs [$];
      int unsigned errors;

      function new();
         current_year = 8'd70;
         errors = 0;
      endfunction

      task report(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function bit [32:0] seconds_since_epoch(input calendar_word_type w);
         longint unsigned yr;
         longint unsigned full_year;
         longint unsigned day_no;
         longint unsigned hour_no;
         longint unsigned days;
         longint unsigned total;
         if (w.month < 4'd1 || w.month > 4'd12) return '0;
         if (w.day < 6'd1 || w.day > 6'd31) return '0;
         day_no = 64'(w.day);
         hour_no = 64'(w.hour);
         // Midnight at the end of a day moves on to the next; the new day is not rechecked.
         if (hour_no == 64'd24) begin
            hour_no = 64'd0;
            day_no = day_no + 64'd1;
         end
         if (w.minute > 6'd59) return '0;
         yr = w.year[8] ? 64'(current_year) : 64'(w.year[7:0]);
         if (hour_no > 64'd23) return '0;
         full_year = yr + 64'd1900;
         days = 64'd0;
         if (full_year > 64'd1970)
            days = (full_year - 64'd1970) * 64'd365 + (full_year - 64'd1) / 64'd4
                   - 64'd1969 / 64'd4;
         if (full_year % 64'd4 == 64'd0 && w.month >= 4'd3) days = days + 64'd1;
         days = days + 64'(DAYS_TO_MONTH[w.month - 4'd1]);
         days = days + day_no - 64'd1;
         total = ((days * 64'd24 + hour_no) * 64'd60 + 64'(w.minute)) * 64'd60
                 + 64'(w.second);
         return total[32:0];
      endfunction

      function void note_request(input calendar_word_type w);
         pending_epochs.push_back(seconds_since_epoch(w));
      endfunction

      task check_response(input logic [RSP_W-1:0] w);
         bit [32:0] want;
         if (pending_epochs.size() == 0) begin
            report($sformatf("response word %h with nothing pending", w));
         end else begin
            want = pending_epochs.pop_front();
            if (w[32:0] !== want)
               report($sformatf("epoch_seconds %0d, predicted %0d", w[32:0], want));
         end
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_data = '0;

   epoch_scoreboard board = new();
   int unsigned cycle_count = 0;
   int unsigned responses = 0;
   int unsigned hold_left = 0;
   int unsigned burst_left = 0;
   calendar_word_type directed_words [$];

   calendar_to_epoch_seconds_core i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver stalls on a pattern that cycle_count[7:6] selects, and twice holds off
   // for a long stretch so that the pipeline fills and the request side stalls.
   always @(posedge clock) begin
      stall_mode_type mode;
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tdata);
         responses <= responses + 1;
         if (responses + 1 == 100 || responses + 1 == 900) hold_left <= LONG_HOLD;
      end
      mode = stall_mode_type'(cycle_count[7:6]);
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         case (mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_HALF: rsp_tready <= 1'($urandom_range(0, 1));
            READY_QUARTER: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   function automatic calendar_word_type make_word(input logic [8:0] yr,
                                                   input int unsigned mon,
                                                   input int unsigned d, input int unsigned h,
                                                   input int unsigned mi, input int unsigned s);
      calendar_word_type w;
      w.fill = '0;
      w.year = yr;
      w.month = 4'(mon);
      w.day = 6'(d);
      w.hour = 5'(h);
      w.minute = 6'(mi);
      w.second = 6'(s);
      return w;
   endfunction

   function automatic calendar_word_type random_word();
      calendar_word_type w;
      w.fill = '0;
      if ($urandom_range(0, 4) == 0) begin
         w.year = 9'($urandom);
         w.month = 4'($urandom);
         w.day = 6'($urandom);
         w.hour = 5'($urandom);
         w.minute = 6'($urandom);
      end else begin
         if ($urandom_range(0, 6) == 0) w.year = {1'b1, 8'($urandom)};
         else w.year = {1'b0, 8'($urandom)};
         w.month = 4'($urandom_range(1, 12));
         w.day = 6'($urandom_range(1, 31));
         w.hour = ($urandom_range(0, 11) == 0) ? 5'd24 : 5'($urandom_range(0, 23));
         w.minute = 6'($urandom_range(0, 59));
      end
      w.second = 6'($urandom);
      return w;
   endfunction

   task automatic offer(input calendar_word_type w);
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      board.note_request(w);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_epochs.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_current_year(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.current_year = value;
   endtask

   initial begin
      logic [7:0] phase_years [5];
      phase_years = '{8'd0, 8'd255, 8'($urandom), 8'($urandom), 8'd69};

      directed_words.push_back(make_word(9'd70, 1, 1, 0, 0, 0));
      directed_words.push_back(make_word(9'd255, 12, 31, 23, 59, 63));
      directed_words.push_back(make_word(9'd255, 12, 31, 24, 59, 63));
      directed_words.push_back(make_word(9'd0, 2, 28, 0, 0, 0));
      directed_words.push_back(make_word(9'd0, 3, 1, 0, 0, 0));
      directed_words.push_back(make_word(9'd72, 2, 29, 12, 30, 30));
      directed_words.push_back(make_word(9'd72, 3, 1, 0, 0, 1));
      directed_words.push_back(make_word(YEAR_NEG_ONE, 6, 15, 10, 10, 10));
      directed_words.push_back(make_word(YEAR_NEG_MIN, 7, 4, 1, 2, 3));
      directed_words.push_back(make_word(9'd80, 0, 10, 5, 5, 5));
      directed_words.push_back(make_word(9'd80, 13, 10, 5, 5, 5));
      directed_words.push_back(make_word(9'd80, 15, 10, 5, 5, 5));
      directed_words.push_back(make_word(9'd80, 5, 0, 5, 5, 5));
      directed_words.push_back(make_word(9'd80, 5, 32, 5, 5, 5));
      directed_words.push_back(make_word(9'd80, 5, 63, 5, 5, 5));
      directed_words.push_back(make_word(9'd80, 5, 10, 25, 5, 5));
      directed_words.push_back(make_word(9'd80, 5, 10, 31, 5, 5));
      directed_words.push_back(make_word(9'd80, 5, 10, 5, 60, 5));
      directed_words.push_back(make_word(9'd80, 5, 10, 5, 63, 5));
      directed_words.push_back(make_word(9'd80, 5, 10, 24, 60, 5));
      directed_words.push_back(make_word(9'd100, 1, 31, 24, 0, 0));
      directed_words.push_back(make_word(9'd69, 12, 31, 23, 59, 63));
      directed_words.push_back(make_word(9'd71, 1, 1, 0, 0, 0));
      directed_words.push_back(make_word(9'd74, 1, 1, 0, 0, 0));
      directed_words.push_back(make_word(YEAR_NEG_ONE, 12, 31, 24, 0, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_words[i]) offer(directed_words[i]);

      foreach (phase_years[p]) begin
         drain();
         write_current_year(phase_years[p]);
         repeat (ITEMS_PER_PHASE) offer(random_word());
      end
      drain();

      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
